[rtl/motor_speed_ramp_reversal_core_assert.svh]
// Assertion macros shared by the checker of the motor speed ramp core.
`ifndef MOTOR_SPEED_RAMP_REVERSAL_CORE_ASSERT_SVH
`define MOTOR_SPEED_RAMP_REVERSAL_CORE_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define MSRR_ASSERT_IMPLY(label, clk_sig, rst_sig, cond, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) \
		(cond) |-> (prop)) else $error("assertion failed: same-cycle implication");

// Checks that a condition implies another in the following cycle.
`define MSRR_ASSERT_NEXT(label, clk_sig, rst_sig, cond, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) \
		(cond) |=> (prop)) else $error("assertion failed: next-cycle implication");

`endif

[rtl/msrr_pkg.sv]
// Package with shared constants and types of the motor speed ramp core.
`default_nettype none
package msrr_pkg;

	localparam int DUTY_WIDTH_DEF  = 8;
	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_FLOOR   = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPEED_CEILING = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_STEP     = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DRIVER_SELECT = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGH_SIDE_LVL = 3'd4;

	localparam int FLOOR_RESET = 5;
	localparam int STEP_RESET  = 2;

	localparam logic [1:0] DIR_STOP = 2'd0;
	localparam logic [1:0] DIR_FWD  = 2'd1;
	localparam logic [1:0] DIR_REV  = 2'd2;

	localparam logic [1:0] DRV_NONE    = 2'd0;
	localparam logic [1:0] DRV_HBRIDGE = 2'd1;
	localparam logic [1:0] DRV_DIR_PWM = 2'd2;

	typedef struct packed {
		logic [1:0] driver_select;
		logic       high_side_active_level;
	} drv_cfg_t;

endpackage
`default_nettype wire

[rtl/motor_speed_ramp_reversal_core.sv]
// Top level of the motor speed ramp and direction reversal core.
//
//   Channel  Signals                              Direction  Meaning
//   in       in_valid, in_ready, target_*, enable  into core  one tick request
//   out      out_valid, out_ready, ramp_*, driver  out of core one result per tick
//   cfg      cfg_we, cfg_index, cfg_data           into core  register write
//
// A request accepted enters the input register and moves into the result register
// once that register is free; its result is offered from the result register.
// A new request can be accepted every cycle unless the output stalls; the ramp state
// updates as a request moves into the result register.
// Reset clears the ramp state to speed zero and stop and loads register defaults.
// A stalled result holds its register; the input register keeps accepting
// until both registers are full.
`default_nettype none
module motor_speed_ramp_reversal_core
	import msrr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [DUTY_WIDTH-1:0]      cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [DUTY_WIDTH-1:0]      target_speed,
	input  wire logic [1:0]                 target_direction,
	input  wire logic                       motor_enable,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [DUTY_WIDTH-1:0]      ramp_speed,
	output logic      [1:0]                 ramp_direction,
	output logic                            driver_ready,
	output logic                            high_side_pos,
	output logic                            high_side_neg,
	output logic      [DUTY_WIDTH-1:0]      low_side_pos_duty,
	output logic      [DUTY_WIDTH-1:0]      low_side_neg_duty,
	output logic                            dir_pin,
	output logic      [DUTY_WIDTH-1:0]      pwm_duty
);

	logic [DUTY_WIDTH-1:0] speed_floor;
	logic [DUTY_WIDTH-1:0] speed_ceiling;
	logic [DUTY_WIDTH-1:0] ramp_step;
	drv_cfg_t              drv_cfg;

	logic                  valid_s1;
	logic [DUTY_WIDTH-1:0] tgt_s1;
	logic [1:0]            tdir_s1;
	logic                  en_s1;

	logic [DUTY_WIDTH-1:0] speed_q;
	logic [1:0]            dir_q;

	logic [DUTY_WIDTH-1:0] speed_next;
	logic [1:0]            dir_next;

	logic                  d_ready;
	logic                  d_hp;
	logic                  d_hn;
	logic [DUTY_WIDTH-1:0] d_lp;
	logic [DUTY_WIDTH-1:0] d_ln;
	logic                  d_dp;
	logic [DUTY_WIDTH-1:0] d_pw;

	logic                  valid_s2;
	logic [DUTY_WIDTH-1:0] speed_s2;
	logic [1:0]            dir_s2;
	logic                  ready_s2;
	logic                  hp_s2;
	logic                  hn_s2;
	logic [DUTY_WIDTH-1:0] lp_s2;
	logic [DUTY_WIDTH-1:0] ln_s2;
	logic                  dp_s2;
	logic [DUTY_WIDTH-1:0] pw_s2;

	logic                  adv_s2;
	logic                  adv_s1;

	msrr_cfg #(.DUTY_WIDTH(DUTY_WIDTH)) u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.speed_floor   (speed_floor),
		.speed_ceiling (speed_ceiling),
		.ramp_step     (ramp_step),
		.drv_cfg       (drv_cfg)
	);

	msrr_ramp #(.DUTY_WIDTH(DUTY_WIDTH)) u_ramp (
		.speed_now        (speed_q),
		.dir_now          (dir_q),
		.target_speed     (tgt_s1),
		.target_direction (tdir_s1),
		.motor_enable     (en_s1),
		.speed_floor      (speed_floor),
		.speed_ceiling    (speed_ceiling),
		.ramp_step        (ramp_step),
		.speed_next       (speed_next),
		.dir_next         (dir_next)
	);

	msrr_drive #(.DUTY_WIDTH(DUTY_WIDTH)) u_drive (
		.speed             (speed_next),
		.dir               (dir_next),
		.drv_cfg           (drv_cfg),
		.driver_ready      (d_ready),
		.high_side_pos     (d_hp),
		.high_side_neg     (d_hn),
		.low_side_pos_duty (d_lp),
		.low_side_neg_duty (d_ln),
		.dir_pin           (d_dp),
		.pwm_duty          (d_pw)
	);

	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			speed_q  <= '0;
			dir_q    <= DIR_STOP;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				speed_q <= speed_next;
				dir_q   <= dir_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tgt_s1  <= target_speed;
			tdir_s1 <= target_direction;
			en_s1   <= motor_enable;
		end
		if (adv_s1) begin
			speed_s2 <= speed_next;
			dir_s2   <= dir_next;
			ready_s2 <= d_ready;
			hp_s2    <= d_hp;
			hn_s2    <= d_hn;
			lp_s2    <= d_lp;
			ln_s2    <= d_ln;
			dp_s2    <= d_dp;
			pw_s2    <= d_pw;
		end
	end

	assign out_valid         = valid_s2;
	assign ramp_speed        = speed_s2;
	assign ramp_direction    = dir_s2;
	assign driver_ready      = ready_s2;
	assign high_side_pos     = hp_s2;
	assign high_side_neg     = hn_s2;
	assign low_side_pos_duty = lp_s2;
	assign low_side_neg_duty = ln_s2;
	assign dir_pin           = dp_s2;
	assign pwm_duty          = pw_s2;

endmodule
`default_nettype wire

[rtl/msrr_cfg.sv]
// Configuration register file of the motor speed ramp core.
`default_nettype none
module msrr_cfg
	import msrr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic [DUTY_WIDTH-1:0]      cfg_data,
	output logic      [DUTY_WIDTH-1:0]      speed_floor,
	output logic      [DUTY_WIDTH-1:0]      speed_ceiling,
	output logic      [DUTY_WIDTH-1:0]      ramp_step,
	output drv_cfg_t                        drv_cfg
);

	logic [DUTY_WIDTH-1:0] floor_q;
	logic [DUTY_WIDTH-1:0] ceiling_q;
	logic [DUTY_WIDTH-1:0] step_q;
	drv_cfg_t              drv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q   <= DUTY_WIDTH'(FLOOR_RESET);
			ceiling_q <= '1;
			step_q    <= DUTY_WIDTH'(STEP_RESET);
			drv_q     <= '{driver_select: DRV_NONE, high_side_active_level: 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SPEED_FLOOR:   floor_q <= cfg_data;
				REG_SPEED_CEILING: ceiling_q <= cfg_data;
				REG_RAMP_STEP:     step_q <= cfg_data;
				REG_DRIVER_SELECT: drv_q.driver_select <= cfg_data[1:0];
				REG_HIGH_SIDE_LVL: drv_q.high_side_active_level <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign speed_floor   = floor_q;
	assign speed_ceiling = ceiling_q;
	assign ramp_step     = step_q;
	assign drv_cfg       = drv_q;

endmodule
`default_nettype wire

[rtl/msrr_ramp.sv]
// Next-state logic of the speed ramp and direction reversal.
`default_nettype none
module msrr_ramp
	import msrr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic [DUTY_WIDTH-1:0] speed_now,
	input  wire logic [1:0]            dir_now,
	input  wire logic [DUTY_WIDTH-1:0] target_speed,
	input  wire logic [1:0]            target_direction,
	input  wire logic                  motor_enable,
	input  wire logic [DUTY_WIDTH-1:0] speed_floor,
	input  wire logic [DUTY_WIDTH-1:0] speed_ceiling,
	input  wire logic [DUTY_WIDTH-1:0] ramp_step,
	output logic      [DUTY_WIDTH-1:0] speed_next,
	output logic      [1:0]            dir_next
);

	logic [DUTY_WIDTH-1:0] step;
	logic [1:0]            tdir;
	logic [DUTY_WIDTH-1:0] tgt;
	logic [DUTY_WIDTH-1:0] sp;
	logic [1:0]            dr;
	logic [DUTY_WIDTH-1:0] sp_clamped;

	always_comb begin
		step = (ramp_step == '0) ? DUTY_WIDTH'(1) : ramp_step;
		tdir = (target_direction == DIR_FWD || target_direction == DIR_REV) ?
			target_direction : DIR_STOP;

		if (target_speed < speed_floor) begin
			tgt = speed_floor;
		end else if (target_speed > speed_ceiling) begin
			tgt = speed_ceiling;
		end else begin
			tgt = target_speed;
		end

		sp = speed_now;
		dr = dir_now;
		if (dir_now != tdir) begin
			if (dir_now == DIR_FWD || dir_now == DIR_REV) begin
				sp = (speed_now > step) ? speed_now - step : '0;
				if (sp <= speed_floor) begin
					dr = tdir;
				end
			end else begin
				dr = tdir;
			end
		end else if (speed_now > tgt) begin
			sp = ((speed_now - tgt) > step) ? speed_now - step : tgt;
		end else if (speed_now < tgt) begin
			sp = ((tgt - speed_now) > step) ? speed_now + step : tgt;
		end

		if (sp > speed_ceiling) begin
			sp_clamped = speed_ceiling;
		end else if (sp < speed_floor) begin
			sp_clamped = speed_floor;
		end else begin
			sp_clamped = sp;
		end

		if (!motor_enable) begin
			speed_next = '0;
			dir_next   = DIR_STOP;
		end else begin
			speed_next = sp_clamped;
			dir_next   = dr;
		end
	end

endmodule
`default_nettype wire

[rtl/msrr_drive.sv]
// Output mapping for the H-bridge and the direction-plus-PWM driver.
`default_nettype none
module msrr_drive
	import msrr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input  wire logic [DUTY_WIDTH-1:0] speed,
	input  wire logic [1:0]            dir,
	input  wire drv_cfg_t              drv_cfg,
	output logic                       driver_ready,
	output logic                       high_side_pos,
	output logic                       high_side_neg,
	output logic      [DUTY_WIDTH-1:0] low_side_pos_duty,
	output logic      [DUTY_WIDTH-1:0] low_side_neg_duty,
	output logic                       dir_pin,
	output logic      [DUTY_WIDTH-1:0] pwm_duty
);

	logic on_lvl;

	always_comb begin
		on_lvl            = drv_cfg.high_side_active_level;
		driver_ready      = 1'b0;
		high_side_pos     = ~on_lvl;
		high_side_neg     = ~on_lvl;
		low_side_pos_duty = '0;
		low_side_neg_duty = '0;
		dir_pin           = 1'b0;
		pwm_duty          = '0;
		unique case (drv_cfg.driver_select)
			DRV_HBRIDGE: begin
				driver_ready = 1'b1;
				if (dir == DIR_FWD) begin
					high_side_pos     = on_lvl;
					low_side_neg_duty = speed;
				end else if (dir == DIR_REV) begin
					high_side_neg     = on_lvl;
					low_side_pos_duty = speed;
				end
			end
			DRV_DIR_PWM: begin
				driver_ready = 1'b1;
				if (dir == DIR_FWD) begin
					pwm_duty = speed;
				end else if (dir == DIR_REV) begin
					dir_pin  = 1'b1;
					pwm_duty = ~speed;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[rtl/msrr_checker.sv]
// Port-level assertion checker of the motor speed ramp core and its bind.
`default_nettype none
`include "motor_speed_ramp_reversal_core_assert.svh"
module msrr_checker
	import msrr_pkg::*;
#(
	parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic [DUTY_WIDTH-1:0] ramp_speed,
	input wire logic [1:0]            ramp_direction,
	input wire logic                  driver_ready,
	input wire logic                  high_side_pos,
	input wire logic                  high_side_neg,
	input wire logic [DUTY_WIDTH-1:0] low_side_pos_duty,
	input wire logic [DUTY_WIDTH-1:0] low_side_neg_duty,
	input wire logic                  dir_pin,
	input wire logic [DUTY_WIDTH-1:0] pwm_duty
);

	// A stalled result keeps its speed and direction.
	`MSRR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(ramp_speed) && $stable(ramp_direction))

	// Without a driver the direction pin and every duty output sit at their idle values.
	`MSRR_ASSERT_IMPLY(a_idle_driver, clk, arst_n, out_valid && !driver_ready,
		!dir_pin && pwm_duty == '0 && low_side_pos_duty == '0 && low_side_neg_duty == '0)

	// The direction never takes the unused code.
	`MSRR_ASSERT_IMPLY(a_dir_code, clk, arst_n, out_valid,
		ramp_direction == DIR_STOP || ramp_direction == DIR_FWD || ramp_direction == DIR_REV)

	// A driven positive low side means the high sides differ, the negative low side is idle and dir_pin is low.
	`MSRR_ASSERT_IMPLY(a_bridge_excl, clk, arst_n, out_valid && low_side_pos_duty != '0,
		high_side_pos != high_side_neg && low_side_neg_duty == '0 && !dir_pin)

endmodule

bind motor_speed_ramp_reversal_core msrr_checker #(.DUTY_WIDTH(DUTY_WIDTH)) u_checker (.*);
`default_nettype wire
